// ===== rtl/mid_pkg.sv =====
package mid_pkg;

    localparam int CoordW   = 32;
    localparam int DiffW    = CoordW + 1;
    localparam int WrapW    = DiffW + 1;
    localparam int MagW     = CoordW + 1;
    localparam int LenW     = 31;
    localparam int HalfW    = LenW - 1;
    localparam int LoSqW    = 2 * CoordW;
    localparam int SqW      = 2 * MagW;
    localparam int RootW    = MagW;
    localparam int NumAxes  = 3;
    localparam int AxisZ    = 2;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_BOX_LEN_X = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_BOX_LEN_Y = 4'd1;
    localparam logic [CfgIdxW-1:0] CFG_BOX_LEN_Z = 4'd2;
    localparam logic [CfgIdxW-1:0] CFG_XY_ONLY   = 4'd3;

    localparam logic [LenW-1:0] BOX_LEN_RESET = 31'd1310720;

endpackage

// ===== rtl/mid_sqrt_pipe.sv =====
module mid_sqrt_pipe
    import mid_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [SqW-1:0]   radicand,
    output logic             out_valid,
    output logic [RootW-1:0] root
);

    // One result bit per stage, restoring digit-by-digit method.
    localparam int NumStages = RootW;
    localparam int RemW      = RootW + 3;

    logic [SqW-1:0]       rad_reg  [NumStages];
    logic [RemW-1:0]      rem_reg  [NumStages];
    logic [RootW-1:0]     root_reg [NumStages];
    logic [NumStages-1:0] vld_reg;

    for (genvar g = 0; g < NumStages; g++) begin : g_stage
        logic [SqW-1:0]   rad_cur;
        logic [RemW-1:0]  rem_cur;
        logic [RootW-1:0] root_cur;
        logic             vld_cur;
        logic [RemW-1:0]  rem_shift;
        logic [RemW-1:0]  trial;
        logic             take;
        logic [SqW-1:0]   rad_next;
        logic [RemW-1:0]  rem_next;
        logic [RootW-1:0] root_next;

        if (g == 0) begin : g_first
            assign rad_cur  = radicand;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign vld_cur  = in_valid;
        end else begin : g_rest
            assign rad_cur  = rad_reg[g-1];
            assign rem_cur  = rem_reg[g-1];
            assign root_cur = root_reg[g-1];
            assign vld_cur  = vld_reg[g-1];
        end

        always_comb begin
            rem_shift = {rem_cur[RemW-3:0], rad_cur[SqW-1 -: 2]};
            trial     = {1'b0, root_cur, 2'b01};
            take      = (rem_shift >= trial);
            rem_next  = take ? (rem_shift - trial) : rem_shift;
            root_next = {root_cur[RootW-2:0], take};
            rad_next  = {rad_cur[SqW-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (adv) begin
                vld_reg[g] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[g]  <= rad_next;
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[NumStages-1];
    assign root      = root_reg[NumStages-1];

endmodule

// ===== rtl/minimum_image_distance.sv =====
// Channel   Direction  Handshake                  Payload
// s_        in         s_valid / s_ready          s_first_{x,y,z}, s_second_{x,y,z}
// m_        out        m_valid / m_ready          m_separation
// cfg_      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle is accepted while s_ready is high; the path to m_valid runs through
// seven displacement/wrap/square stages, the first loaded at the accepting edge, 33 square-root
// stages and the output buffer. The square-root chain, one result bit per stage, sets
// the depth.
// Synchronous active-low reset clears all valid bits, the buffer count and the
// box registers to their defaults. A two-entry output buffer lets the pipeline
// run while a result waits; when it is full, the whole pipeline holds and s_ready drops.
module minimum_image_distance
    import mid_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [CoordW-1:0] s_first_x,
    input  logic signed [CoordW-1:0] s_first_y,
    input  logic signed [CoordW-1:0] s_first_z,
    input  logic signed [CoordW-1:0] s_second_x,
    input  logic signed [CoordW-1:0] s_second_y,
    input  logic signed [CoordW-1:0] s_second_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RootW-1:0]        m_separation,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxW-1:0]      cfg_index,
    input  logic [CfgDataW-1:0]     cfg_data
);

    localparam int FrontStages = 7;

    logic [LenW-1:0] box_len_reg [NumAxes];
    logic            xy_only_reg;

    logic                   adv;
    logic [1:0]             cnt_reg;
    logic [FrontStages-1:0] front_vld_reg;

    logic signed [CoordW-1:0] first_pos  [NumAxes];
    logic signed [CoordW-1:0] second_pos [NumAxes];
    logic [NumAxes-1:0]       wrap_en;
    logic [HalfW-1:0]         half       [NumAxes];

    logic signed [DiffW-1:0] diff_next  [NumAxes];
    logic signed [DiffW-1:0] diff_reg   [NumAxes];
    logic signed [WrapW-1:0] wrap1_next [NumAxes];
    logic signed [WrapW-1:0] wrap1_reg  [NumAxes];
    logic signed [WrapW-1:0] wrap2_next [NumAxes];
    logic signed [WrapW-1:0] wrap2_reg  [NumAxes];
    logic signed [WrapW-1:0] neg_tmp    [NumAxes];
    logic [MagW-1:0]         mag_next   [NumAxes];
    logic [MagW-1:0]         mag_reg    [NumAxes];
    logic [MagW-1:0]         mag5_reg   [NumAxes];
    logic [LoSqW-1:0]        lo_sq_reg  [NumAxes];
    logic [SqW-1:0]          sq_next    [NumAxes];
    logic [SqW-1:0]          sq_reg     [NumAxes];
    logic [SqW-1:0]          sum_reg;

    logic             root_vld;
    logic [RootW-1:0] root;
    logic             push;
    logic             pop;
    logic [RootW-1:0] out_buf_reg [2];

    // Configuration.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_len_reg[0] <= BOX_LEN_RESET;
            box_len_reg[1] <= BOX_LEN_RESET;
            box_len_reg[2] <= BOX_LEN_RESET;
            xy_only_reg    <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BOX_LEN_X: box_len_reg[0] <= cfg_data[LenW-1:0];
                CFG_BOX_LEN_Y: box_len_reg[1] <= cfg_data[LenW-1:0];
                CFG_BOX_LEN_Z: box_len_reg[2] <= cfg_data[LenW-1:0];
                CFG_XY_ONLY:   xy_only_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output buffer has a free entry.
    assign adv     = (cnt_reg != 2'd2);
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= '0;
        end else if (adv) begin
            front_vld_reg <= {front_vld_reg[FrontStages-2:0], s_valid};
        end
    end

    assign first_pos[0]  = s_first_x;
    assign first_pos[1]  = s_first_y;
    assign first_pos[2]  = s_first_z;
    assign second_pos[0] = s_second_x;
    assign second_pos[1] = s_second_y;
    assign second_pos[2] = s_second_z;

    always_comb begin
        for (int a = 0; a < NumAxes; a++) begin
            wrap_en[a] = (a != AxisZ) || !xy_only_reg;
            half[a]    = box_len_reg[a][LenW-1:1];

            diff_next[a] = $signed({second_pos[a][CoordW-1], second_pos[a]})
                         - $signed({first_pos[a][CoordW-1], first_pos[a]});

            // Below minus half the box: add one box length.
            if (wrap_en[a] && ($signed({diff_reg[a][DiffW-1], diff_reg[a]})
                    < -$signed({4'b0, half[a]}))) begin
                wrap1_next[a] = {diff_reg[a][DiffW-1], diff_reg[a]}
                              + $signed({3'b0, box_len_reg[a]});
            end else begin
                wrap1_next[a] = {diff_reg[a][DiffW-1], diff_reg[a]};
            end

            // Above half the box: subtract one box length.
            if (wrap_en[a] && (wrap1_reg[a] > $signed({4'b0, half[a]}))) begin
                wrap2_next[a] = wrap1_reg[a] - $signed({3'b0, box_len_reg[a]});
            end else begin
                wrap2_next[a] = wrap1_reg[a];
            end

            neg_tmp[a]  = -wrap2_reg[a];
            mag_next[a] = wrap2_reg[a][WrapW-1] ? neg_tmp[a][MagW-1:0]
                                                : wrap2_reg[a][MagW-1:0];

            // The magnitude's top bit adds 2*lo*2^32 + 2^64 to the low square.
            sq_next[a] = {2'b00, lo_sq_reg[a]}
                       + (mag5_reg[a][MagW-1] ? {1'b0, mag5_reg[a][CoordW-1:0], 33'b0}
                                              : {SqW{1'b0}})
                       + {1'b0, mag5_reg[a][MagW-1], {LoSqW{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < NumAxes; a++) begin
                diff_reg[a]  <= diff_next[a];
                wrap1_reg[a] <= wrap1_next[a];
                wrap2_reg[a] <= wrap2_next[a];
                mag_reg[a]   <= mag_next[a];
                mag5_reg[a]  <= mag_reg[a];
                lo_sq_reg[a] <= mag_reg[a][CoordW-1:0] * mag_reg[a][CoordW-1:0];
                sq_reg[a]    <= sq_next[a];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    mid_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_vld_reg[FrontStages-1]),
        .radicand  (sum_reg),
        .out_valid (root_vld),
        .root      (root)
    );

    // Two-entry output buffer; entry zero is the head.
    assign push = adv && root_vld;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_buf_reg[0] <= out_buf_reg[1];
        end
        if (push) begin
            if ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop)) begin
                out_buf_reg[0] <= root;
            end else begin
                out_buf_reg[1] <= root;
            end
        end
    end

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_separation = out_buf_reg[0];

endmodule

// ===== rtl/mid_checker.sv =====
module mid_checker
    import mid_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [RootW-1:0] m_separation
);

    // A waiting result is never withdrawn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the item was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_separation))
        else $error("m_separation changed while stalled");

    // Reset empties the output buffer.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // With no result waiting, the buffer has room and the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while the output buffer is empty");

endmodule

bind minimum_image_distance mid_checker u_mid_checker (.*);

// ===== tb/separation_checker.sv =====
`timescale 1ns / 1ps

module separation_checker
    import mid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [CoordW-1:0] s_first_x,
    input  logic signed [CoordW-1:0] s_first_y,
    input  logic signed [CoordW-1:0] s_first_z,
    input  logic signed [CoordW-1:0] s_second_x,
    input  logic signed [CoordW-1:0] s_second_y,
    input  logic signed [CoordW-1:0] s_second_z,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [RootW-1:0]         m_separation,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgDataW-1:0]      cfg_data,
    output int                       error_count,
    output int                       pairs_in_flight
);

    logic [LenW-1:0]  box_x;
    logic [LenW-1:0]  box_y;
    logic [LenW-1:0]  box_z;
    logic             wrap_xy_only;
    logic [RootW-1:0] expected_separations[$];

    initial begin
        error_count = 0;
        pairs_in_flight = 0;
    end

    // One minimum-image correction; a far-out component may stay outside the half box.
    function automatic longint fold_axis(input longint disp, input logic [LenW-1:0] len);
        longint span;
        longint half_span;
        span = longint'(len);
        half_span = longint'(len >> 1);
        if (disp < -half_span) begin
            disp = disp + span;
        end
        if (disp > half_span) begin
            disp = disp - span;
        end
        return disp;
    endfunction

    function automatic logic [RootW-1:0] min_image_separation(
        input logic signed [CoordW-1:0] ax,
        input logic signed [CoordW-1:0] ay,
        input logic signed [CoordW-1:0] az,
        input logic signed [CoordW-1:0] bx,
        input logic signed [CoordW-1:0] by,
        input logic signed [CoordW-1:0] bz
    );
        longint       dx;
        longint       dy;
        longint       dz;
        logic [127:0] mx;
        logic [127:0] my;
        logic [127:0] mz;
        logic [127:0] sum_sq;
        logic [127:0] cand_sq;
        logic [33:0]  root;
        logic [33:0]  cand;
        dx = fold_axis(longint'(bx) - longint'(ax), box_x);
        dy = fold_axis(longint'(by) - longint'(ay), box_y);
        dz = longint'(bz) - longint'(az);
        if (!wrap_xy_only) begin
            dz = fold_axis(dz, box_z);
        end
        mx = 128'(dx < 0 ? -dx : dx);
        my = 128'(dy < 0 ? -dy : dy);
        mz = 128'(dz < 0 ? -dz : dz);
        sum_sq = mx * mx + my * my + mz * mz;
        // Bitwise floor square root, most significant bit first.
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            cand_sq = 128'(cand) * 128'(cand);
            if (cand_sq <= sum_sq) begin
                root = cand;
            end
        end
        return root[RootW-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [RootW-1:0] want;
        if (!aresetn) begin
            box_x = BOX_LEN_RESET;
            box_y = BOX_LEN_RESET;
            box_z = BOX_LEN_RESET;
            wrap_xy_only = 1'b0;
            expected_separations.delete();
            pairs_in_flight = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_separations.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected separation item %h", m_separation);
                    end
                    error_count = error_count + 1;
                end else begin
                    want = expected_separations.pop_front();
                    if (m_separation !== want) begin
                        if (error_count < 10) begin
                            $display("separation mismatch: expected %h, got %h",
                                     want, m_separation);
                        end
                        error_count = error_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_separations.push_back(min_image_separation(
                    s_first_x, s_first_y, s_first_z, s_second_x, s_second_y, s_second_z));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BOX_LEN_X: box_x = cfg_data[LenW-1:0];
                    CFG_BOX_LEN_Y: box_y = cfg_data[LenW-1:0];
                    CFG_BOX_LEN_Z: box_z = cfg_data[LenW-1:0];
                    CFG_XY_ONLY:   wrap_xy_only = cfg_data[0];
                    default: ;
                endcase
            end
            pairs_in_flight = expected_separations.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import mid_pkg::*;
();

    typedef logic signed [CoordW-1:0] coord_t;

    localparam int     ResetCycles   = 7;
    localparam int     HoldCycles    = 400;
    localparam int     PairsPerMode  = 60;
    localparam int     PressurePairs = 150;
    localparam int     NumSettings   = 6;
    localparam int     TailCycles    = 60;
    localparam int     CycleLimit    = 300000;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 4'd15;
    localparam coord_t MinCoord = 32'sh8000_0000;
    localparam coord_t MaxCoord = 32'sh7FFF_FFFF;
    localparam coord_t DefLen   = coord_t'(BOX_LEN_RESET);
    localparam coord_t DefHalf  = coord_t'(BOX_LEN_RESET >> 1);

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    coord_t              s_first_x;
    coord_t              s_first_y;
    coord_t              s_first_z;
    coord_t              s_second_x;
    coord_t              s_second_y;
    coord_t              s_second_z;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [RootW-1:0]    m_separation;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    int                  error_count;
    int                  pairs_in_flight;
    int                  cycle_count = 0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_left = 0;
    logic                hold_req = 1'b0;
    logic                hold_ack = 1'b0;
    logic [LenW-1:0]     box_len[NumAxes];
    int                  idle_mode[4] = '{0, 67, 0, 35};
    int                  stall_mode[4] = '{0, 0, 67, 35};

    always #6 aclk = ~aclk;

    minimum_image_distance i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_first_x   (s_first_x),
        .s_first_y   (s_first_y),
        .s_first_z   (s_first_z),
        .s_second_x  (s_second_x),
        .s_second_y  (s_second_y),
        .s_second_z  (s_second_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_separation(m_separation),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    separation_checker separation_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_first_z      (s_first_z),
        .s_second_x     (s_second_x),
        .s_second_y     (s_second_y),
        .s_second_z     (s_second_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_separation   (m_separation),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .pairs_in_flight(pairs_in_flight)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver; a hold request makes it refuse items for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HoldCycles;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_pair(input coord_t ax, input coord_t ay, input coord_t az,
                              input coord_t bx, input coord_t by, input coord_t bz);
        // Each cycle is idle with the chosen probability before the item is offered.
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first_x <= ax;
        s_first_y <= ay;
        s_first_z <= az;
        s_second_x <= bx;
        s_second_y <= by;
        s_second_z <= bz;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Offsets cluster around the half box or spread up to one and a half boxes, so that wrapping is hit often.
    task automatic pick_axis(input logic [LenW-1:0] len, output coord_t a, output coord_t b);
        longint half_len;
        longint off;
        int     pick;
        half_len = longint'(len >> 1);
        a = coord_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 25) begin
            off = longint'(coord_t'($urandom));
        end else if (pick < 55) begin
            off = longint'($urandom_range(32'(len) + 32'(half_len)));
        end else if (pick < 85) begin
            off = half_len + longint'($urandom_range(2)) - 1;
        end else begin
            off = longint'($urandom_range(255)) - 128;
        end
        if ($urandom_range(1) == 1) begin
            off = -off;
        end
        b = coord_t'(longint'(a) + off);
    endtask

    task automatic offer_random_pairs(input int count);
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        repeat (count) begin
            pick_axis(box_len[0], ax, bx);
            pick_axis(box_len[1], ay, by);
            pick_axis(box_len[AxisZ], az, bz);
            offer_pair(ax, ay, az, bx, by, bz);
        end
    endtask

    // Valid stays high across back-to-back writes; the caller lowers it afterwards.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BOX_LEN_X: box_len[0] = data[LenW-1:0];
            CFG_BOX_LEN_Y: box_len[1] = data[LenW-1:0];
            CFG_BOX_LEN_Z: box_len[AxisZ] = data[LenW-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pairs_in_flight != 0);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_first_x <= '0;
        s_first_y <= '0;
        s_first_z <= '0;
        s_second_x <= '0;
        s_second_y <= '0;
        s_second_z <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BOX_LEN_X;
        cfg_data <= '0;
        for (int i = 0; i < NumAxes; i++) begin
            box_len[i] = BOX_LEN_RESET;
        end
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pairs with the reset box: half-box boundaries, far-out offsets and
        // the coordinate extremes.
        offer_pair(0, 0, 0, 0, 0, 0);
        offer_pair(0, 0, 0, DefHalf, 0, 0);
        offer_pair(0, 0, 0, DefHalf + 1, 0, 0);
        offer_pair(0, 0, 0, -DefHalf, 0, 0);
        offer_pair(0, 0, 0, -DefHalf - 1, 0, 0);
        offer_pair(0, 0, 0, 0, DefHalf + 1, -DefHalf - 1);
        offer_pair(0, 0, 0, DefLen, -DefLen, DefHalf);
        offer_pair(0, 0, 0, 3 * DefLen, -3 * DefLen, 5 * DefLen);
        offer_pair(MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, MaxCoord);
        offer_pair(MaxCoord, MaxCoord, MaxCoord, MinCoord, MinCoord, MinCoord);
        offer_pair(MaxCoord, MinCoord, MaxCoord, MaxCoord, MinCoord, MaxCoord);
        offer_pair(-1, -1, -1, 0, 0, 0);
        offer_pair(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                   32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA);
        offer_pair(MinCoord, 0, MaxCoord, MaxCoord, -1, MinCoord);

        for (int setting = 0; setting < NumSettings; setting++) begin
            settle();
            case (setting)
                1: begin
                    write_reg(CFG_BOX_LEN_X, 32'h7FFF_FFFF);
                    write_reg(CFG_BOX_LEN_Y, 32'h7FFF_FFFF);
                    write_reg(CFG_BOX_LEN_Z, 32'h7FFF_FFFF);
                    write_reg(CFG_XY_ONLY, 32'd0);
                end
                2: begin
                    write_reg(CFG_BOX_LEN_X, 32'd1);
                    write_reg(CFG_BOX_LEN_Y, 32'd1);
                    write_reg(CFG_BOX_LEN_Z, 32'd1);
                    write_reg(CFG_XY_ONLY, 32'd1);
                end
                3: begin
                    // Odd lengths, junk in the upper data bits and a write to no register.
                    write_reg(CFG_BOX_LEN_X, 32'd1310721);
                    write_reg(CFG_BOX_LEN_Y, 32'd2999999);
                    write_reg(CFG_BOX_LEN_Z, 32'h8001_0001);
                    write_reg(CFG_XY_ONLY, 32'hFFFF_FFFE);
                    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
                end
                4: begin
                    // A zero length leaves the component unwrapped.
                    write_reg(CFG_BOX_LEN_X, 32'd0);
                    write_reg(CFG_BOX_LEN_Y, 32'd0);
                    write_reg(CFG_BOX_LEN_Z, 32'd0);
                    write_reg(CFG_XY_ONLY, 32'd0);
                end
                5: begin
                    write_reg(CFG_BOX_LEN_X, $urandom >> $urandom_range(31));
                    write_reg(CFG_BOX_LEN_Y, $urandom >> $urandom_range(31));
                    write_reg(CFG_BOX_LEN_Z, $urandom >> $urandom_range(31));
                    write_reg(CFG_XY_ONLY, $urandom);
                end
                default: ;
            endcase
            cfg_valid <= 1'b0;
            for (int mode = 0; mode < 4; mode++) begin
                idle_pct = idle_mode[mode];
                stall_pct <= stall_mode[mode];
                offer_random_pairs(PairsPerMode);
            end
        end

        // Back-pressure: the receiver holds off while items keep coming at full rate.
        settle();
        idle_pct = 0;
        stall_pct <= 0;
        hold_req <= ~hold_req;
        offer_random_pairs(PressurePairs);

        settle();
        repeat (TailCycles) @(posedge aclk);
        if (error_count == 0 && pairs_in_flight == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
